[rtl/rthit_pkg.sv]
package rthit_pkg;

    localparam int COORD_BITS = 16;
    localparam int LANE_BITS  = 16;
    localparam int POINT_BITS = 3 * LANE_BITS;
    localparam int IN_DATA_W  = ((5 * POINT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;
    localparam int EPS_W      = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = 2 * DW + 1;
    localparam int PW = DW + CW;
    localparam int SW = PW + 3;

    typedef logic [POINT_BITS-1:0] point_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
    } pvec_t;

    function automatic logic signed [DW-1:0] coord(input point_t pt, input int lane);
        logic signed [COORD_BITS-1:0] raw;
        raw = $signed(pt[lane*LANE_BITS +: COORD_BITS]);
        return DW'(raw);
    endfunction

    function automatic dvec_t unpack(input point_t pt);
        dvec_t r;
        r.x = coord(pt, 0);
        r.y = coord(pt, 1);
        r.z = coord(pt, 2);
        return r;
    endfunction

    function automatic dvec_t vsub(input dvec_t a, input dvec_t b);
        dvec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] cross_term(
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] c, input logic signed [DW-1:0] d);
        return CW'(a) * CW'(b) - CW'(c) * CW'(d);
    endfunction

    function automatic cvec_t vcross(input dvec_t a, input dvec_t b);
        cvec_t r;
        r.x = cross_term(a.y, b.z, a.z, b.y);
        r.y = cross_term(a.z, b.x, a.x, b.z);
        r.z = cross_term(a.x, b.y, a.y, b.x);
        return r;
    endfunction

    function automatic pvec_t vmul(input dvec_t a, input cvec_t b);
        pvec_t r;
        r.x = PW'(a.x) * PW'(b.x);
        r.y = PW'(a.y) * PW'(b.y);
        r.z = PW'(a.z) * PW'(b.z);
        return r;
    endfunction

    function automatic logic signed [SW-1:0] vsum(input pvec_t p);
        return SW'(p.x) + SW'(p.y) + SW'(p.z);
    endfunction

endpackage

[rtl/ray_triangle_hit_test_unit.sv]
// Integer Moller-Trumbore test of a ray or a segment against one triangle. A request carries
// five packed points in s_axis_tdata and the mode in s_axis_tuser (0 ray, 1 segment); the
// result is a single hit bit in m_axis_tdata. The unit is a five-stage pipeline that takes a
// new request in every cycle while the output side does not stall; its stages are the edge
// subtract, cross-product multiply, dot-product multiply, sum and compare stages. A stall on
// the output freezes every stage. The determinant threshold det_epsilon resets to one and may
// be written only while idle.
module ray_triangle_hit_test_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             det_epsilon_we,
    input  logic [rthit_pkg::EPS_W-1:0]      det_epsilon_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_point, second_point, vertex_a, vertex_b, vertex_c
    input  logic [rthit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit, then zero fill
    output logic [rthit_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rthit_pkg::*;

    logic [EPS_W-1:0] eps_reg;
    logic             adv;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic  seg1_reg, seg2_reg, seg3_reg, seg4_reg;
    dvec_t d1_reg, e1_1_reg, e2_1_reg, tv1_reg;
    dvec_t d2_reg, e1_2_reg, e2_2_reg, tv2_reg;
    cvec_t pv2_reg, qv2_reg;
    pvec_t det_p_reg, u_p_reg, v_p_reg, t_p_reg;
    logic signed [SW-1:0] det_reg, u_reg, v_reg, t_reg;
    logic  hit_reg;

    dvec_t sp, pp, ap, bp, cp, d1_next;
    logic  seg_in;
    logic  hit_next;
    logic signed [SW-1:0] adet, au, av, at, auv, eps_ext;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 1)'(0), hit_reg};

    always_comb
    begin
        seg_in = s_axis_tuser;
        sp = unpack(s_axis_tdata[0*POINT_BITS +: POINT_BITS]);
        pp = unpack(s_axis_tdata[1*POINT_BITS +: POINT_BITS]);
        ap = unpack(s_axis_tdata[2*POINT_BITS +: POINT_BITS]);
        bp = unpack(s_axis_tdata[3*POINT_BITS +: POINT_BITS]);
        cp = unpack(s_axis_tdata[4*POINT_BITS +: POINT_BITS]);
        d1_next = seg_in ? vsub(pp, sp) : pp;
    end

    // Negating all four terms when det is negative turns the ratio bounds into plain compares.
    always_comb
    begin
        adet    = det_reg[SW-1] ? -det_reg : det_reg;
        au      = det_reg[SW-1] ? -u_reg   : u_reg;
        av      = det_reg[SW-1] ? -v_reg   : v_reg;
        at      = det_reg[SW-1] ? -t_reg   : t_reg;
        auv     = au + av;
        eps_ext = signed'(SW'(eps_reg));
        hit_next = (adet >= eps_ext) && !au[SW-1] && (au <= adet)
                   && !av[SW-1] && (auv <= adet) && !at[SW-1] && (at != '0)
                   && (!seg4_reg || (at < adet));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (det_epsilon_we)
        begin
            eps_reg <= det_epsilon_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg1_reg  <= seg_in;
            d1_reg    <= d1_next;
            e1_1_reg  <= vsub(bp, ap);
            e2_1_reg  <= vsub(cp, ap);
            tv1_reg   <= vsub(sp, ap);

            seg2_reg  <= seg1_reg;
            d2_reg    <= d1_reg;
            e1_2_reg  <= e1_1_reg;
            e2_2_reg  <= e2_1_reg;
            tv2_reg   <= tv1_reg;
            pv2_reg   <= vcross(d1_reg, e2_1_reg);
            qv2_reg   <= vcross(tv1_reg, e1_1_reg);

            seg3_reg  <= seg2_reg;
            det_p_reg <= vmul(e1_2_reg, pv2_reg);
            u_p_reg   <= vmul(tv2_reg, pv2_reg);
            v_p_reg   <= vmul(d2_reg, qv2_reg);
            t_p_reg   <= vmul(e2_2_reg, qv2_reg);

            seg4_reg  <= seg3_reg;
            det_reg   <= vsum(det_p_reg);
            u_reg     <= vsum(u_p_reg);
            v_reg     <= vsum(v_p_reg);
            t_reg     <= vsum(t_p_reg);

            hit_reg   <= hit_next;
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted request did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("pipeline valid bits moved during a stall");

    a_last_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && adv |=> m_axis_tvalid)
        else $error("last stage item did not reach the output");

    a_eps_write: assert property (@(posedge clk) disable iff (!rst_n)
        det_epsilon_we |=> eps_reg == $past(det_epsilon_wdata))
        else $error("threshold write was not taken");

endmodule
